// ===== sv/deq_pkg.sv =====
package deq_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_LIST       = 3'd4;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

  localparam logic [2:0] CELL_HOLD      = 3'd0;
  localparam logic [2:0] CELL_SHIFT_IN  = 3'd1;
  localparam logic [2:0] CELL_SHIFT_OUT = 3'd2;
  localparam logic [2:0] CELL_LOAD_END  = 3'd3;
  localparam logic [2:0] CELL_ROTATE    = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    data_t      push_data;
  } cell_ctl_t;

endpackage

// ===== sv/deq_cell.sv =====
module deq_cell
  import deq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  data_t     left_data,
  input  data_t     right_data,
  input  data_t     head_data,
  input  logic      at_tail,
  input  logic      at_end,
  output data_t     data_q
);

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_SHIFT_IN:  data_nxt = left_data;
      CELL_SHIFT_OUT: data_nxt = right_data;
      CELL_LOAD_END:  data_nxt = at_end ? ctl.push_data : data_r;
      CELL_ROTATE:    data_nxt = at_tail ? head_data : right_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== sv/double_ended_queue.sv =====
// channel  direction  handshake          payload
// in_      input      in_valid/in_stall   in_kind, in_value
// out_     output     out_valid/out_stall out_element, out_has_element, out_status, out_last
//
// push and pop: result the cycle after acceptance; one item per cycle unless stalled
// list of n elements: n results, one per cycle unless stalled, as the cell row rotates once
// list of an empty queue or a push/pop: one result; unused kinds give none
// reset (rst_n low at a clock edge) empties the queue; cell contents are not cleared
// a stalled result holds in the output register; the next item is taken as it leaves
module double_ended_queue
  import deq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  data_t       in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output data_t       out_element,
  output logic        out_has_element,
  output logic [1:0]  out_status,
  output logic        out_last
);

  cnt_t        count_r, count_nxt;
  logic        busy_r, busy_nxt;
  cnt_t        rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  data_t       out_element_r, out_element_nxt;
  logic        out_has_r, out_has_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free;
  logic        accept;
  logic        full;
  logic        empty;
  logic        list_start;
  logic        list_step;
  cell_ctl_t   ctl;
  data_t       cell_data [DEPTH];

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = busy_r || !out_free;
  assign accept     = in_valid && !in_stall;
  assign full       = (count_r == cnt_t'(DEPTH));
  assign empty      = (count_r == '0);
  assign list_start = accept && (in_kind == KIND_LIST) && !empty;
  assign list_step  = busy_r && out_free;

  always_comb begin
    ctl.op        = CELL_HOLD;
    ctl.push_data = in_value;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    out_valid_nxt   = out_valid_r;
    out_element_nxt = out_element_r;
    out_has_nxt     = out_has_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    if (list_step) begin
      ctl.op          = CELL_ROTATE;
      out_valid_nxt   = 1'b1;
      out_element_nxt = cell_data[0];
      out_has_nxt     = 1'b1;
      out_status_nxt  = STATUS_OK;
      out_last_nxt    = (rem_r == cnt_t'(1));
      rem_nxt         = rem_r - cnt_t'(1);
      busy_nxt        = (rem_r != cnt_t'(1));
    end else if (accept) begin
      out_element_nxt = '0;
      out_has_nxt     = 1'b0;
      out_status_nxt  = STATUS_OK;
      out_last_nxt    = 1'b1;
      unique case (in_kind) inside
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_status_nxt = STATUS_PUSH_FULL;
          end else begin
            ctl.op    = (in_kind == KIND_PUSH_FRONT) ? CELL_SHIFT_IN : CELL_LOAD_END;
            count_nxt = count_r + cnt_t'(1);
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            out_status_nxt = STATUS_POP_EMPTY;
          end else begin
            ctl.op    = (in_kind == KIND_POP_FRONT) ? CELL_SHIFT_OUT : CELL_HOLD;
            count_nxt = count_r - cnt_t'(1);
          end
        end
        KIND_LIST: begin
          out_valid_nxt = 1'b1;
          if (list_start) begin
            ctl.op          = CELL_ROTATE;
            out_element_nxt = cell_data[0];
            out_has_nxt     = 1'b1;
            out_last_nxt    = (count_r == cnt_t'(1));
            rem_nxt         = count_r - cnt_t'(1);
            busy_nxt        = (count_r != cnt_t'(1));
          end
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      data_t left_d;
      data_t right_d;
      logic  tail;
      logic  end_pos;

      if (gi == 0) begin : g_first
        assign left_d = in_value;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end

      assign tail    = (count_r == cnt_t'(gi + 1));
      assign end_pos = (count_r == cnt_t'(gi));

      deq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .left_data  (left_d),
        .right_data (right_d),
        .head_data  (cell_data[0]),
        .at_tail    (tail),
        .at_end     (end_pos),
        .data_q     (cell_data[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_element_r <= out_element_nxt;
    out_has_r     <= out_has_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_element     = out_element_r;
  assign out_has_element = out_has_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

// ===== sv/deq_chk.sv =====
module deq_chk
  import deq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_kind,
  input data_t       in_value,
  input logic        out_valid,
  input logic        out_stall,
  input data_t       out_element,
  input logic        out_has_element,
  input logic [1:0]  out_status,
  input logic        out_last
);

  // listed elements always carry ok status
  a_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_element |-> out_status == STATUS_OK)
    else $error("listed element with non-ok status");

  // status and empty-list results are single and zero-valued
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_element |-> out_last && out_element == '0)
    else $error("status result not last or element not zero");

  // a list in flight holds off new items until its last element is taken
  a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_has_element && !out_last |-> in_stall)
    else $error("item taken while list still streaming");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element) && $stable(out_last))
    else $error("stalled result changed");

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind) && $stable(in_value))
    else $error("stalled input item changed");

endmodule

bind double_ended_queue deq_chk u_deq_chk (.*);
